/* rtl/hex_to_base64_encoder_macros.svh */
// ----------------------------------------------------------------------------
// hex_to_base64_encoder assertion macros
// shared concurrent assertion forms for the encoder checker
// ----------------------------------------------------------------------------
`ifndef HEX_TO_BASE64_ENCODER_MACROS_SVH
`define HEX_TO_BASE64_ENCODER_MACROS_SVH

// same-cycle implication
`define H2B64_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h2b64 check failed");

// next-cycle implication
`define H2B64_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h2b64 check failed");

`endif

/* rtl/h2b64_pkg.sv */
// ----------------------------------------------------------------------------
// h2b64_pkg
// types, constants and lookup functions for the hex to base64 encoder
// ----------------------------------------------------------------------------
package h2b64_pkg;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [7:0]  PAD_CHAR    = 8'h3D;
   localparam logic [3:0]  SEXTET_BITS = 4'd6;

   // accepted input transaction
   typedef struct packed {
      logic [7:0] hex_char;
      logic       end_of_message;
   } item_type;

   // characters produced by one input transaction
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] chars;
      logic [MAX_RESULTS-1:0]      lasts;
      logic [2:0]                  count;
   } bundle_type;

   // one queued output character
   typedef struct packed {
      logic [7:0] b64_char;
      logic       last_out;
   } entry_type;

   // {is_hex, nibble}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // standard base64 alphabet
   function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
      logic [7:0] r;
      if (idx < 6'd26) begin
         r = 8'h41 + {2'b00, idx};
      end else if (idx < 6'd52) begin
         r = 8'h47 + {2'b00, idx};
      end else if (idx < 6'd62) begin
         r = {2'b00, idx} - 8'h04;
      end else if (idx == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage

/* rtl/h2b64_stage.sv */
// ----------------------------------------------------------------------------
// h2b64_stage
// input register for the hex character stream
// ----------------------------------------------------------------------------
module h2b64_stage
   import h2b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] hex_char
   input  logic       req_tlast,   // end_of_message
   input  logic       take,
   output logic       item_valid,
   output item_type   item
);

   logic     valid_ff, valid_in;
   item_type item_ff,  item_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff && !take;
      item_in  = item_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         item_in  = '{hex_char: req_tdata, end_of_message: req_tlast};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/h2b64_core.sv */
// ----------------------------------------------------------------------------
// h2b64_core
// sextet packing, flush and padding for one staged character
// ----------------------------------------------------------------------------
module h2b64_core
   import h2b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       room,
   output logic       take,
   output bundle_type bundle
);

   logic [4:0] bits_ff,  bits_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] phase_ff, phase_in;

   logic [4:0] dec;
   logic [3:0] cnt_sum;
   logic [3:0] cnt_a;
   logic [8:0] acc;
   logic [8:0] acc_m;
   logic [4:0] bits_h;
   logic [2:0] cnt_h;
   logic [1:0] phase_c;
   logic [2:0] n;
   logic [2:0] pads;
   logic [2:0] cap;
   logic [2:0] shamt;
   logic [5:0] flush_idx;

   assign take = item_valid && room;

   always_comb begin
      dec       = hex_nibble(item.hex_char);
      cnt_sum   = {1'b0, count_ff} + 4'd4;
      acc       = {bits_ff, dec[3:0]};
      cnt_a     = 4'd0;
      acc_m     = acc;
      bits_h    = bits_ff;
      cnt_h     = count_ff;
      n         = 3'd0;
      pads      = 3'd0;
      cap       = 3'd0;
      shamt     = 3'd0;
      flush_idx = 6'd0;
      bundle    = '0;

      if (dec[4]) begin
         if (cnt_sum >= SEXTET_BITS) begin
            cnt_a           = cnt_sum - SEXTET_BITS;
            bundle.chars[0] = b64_symbol(6'(acc >> cnt_a));
            n               = 3'd1;
            acc_m           = acc & ~(9'h1FF << cnt_a);
            cnt_h           = cnt_a[2:0];
            bits_h          = acc_m[4:0];
         end else begin
            cnt_h  = cnt_sum[2:0];
            bits_h = acc[4:0];
         end
      end

      phase_c  = phase_ff + n[1:0];
      phase_in = phase_c;
      bits_in  = bits_h;
      count_in = cnt_h;

      if (item.end_of_message) begin
         // zero-fill leftover bits on the right
         if (cnt_h != 3'd0 && cnt_h < 3'd6) begin
            shamt                 = 3'd6 - cnt_h;
            flush_idx             = 6'({1'b0, bits_h} << shamt);
            bundle.chars[n[1:0]]  = b64_symbol(flush_idx);
            n                     = n + 3'd1;
            phase_c               = phase_c + 2'd1;
         end
         // pad to a multiple of four characters
         pads = {1'b0, 2'(2'd0 - phase_c)};
         cap  = 3'd4 - n;
         if (pads > cap) begin
            pads = cap;
         end
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (3'(i) >= n && 3'(i) < n + pads) begin
               bundle.chars[i] = PAD_CHAR;
            end
         end
         n = n + pads;
         if (n != 3'd0) begin
            bundle.lasts[2'(n - 3'd1)] = 1'b1;
         end
         bits_in  = 5'd0;
         count_in = 3'd0;
         phase_in = 2'd0;
      end
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= 5'd0;
         count_ff <= 3'd0;
         phase_ff <= 2'd0;
      end else if (take) begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* rtl/h2b64_queue.sv */
// ----------------------------------------------------------------------------
// h2b64_queue
// result character queue, takes up to four per cycle, sends one per cycle while rsp_tready is high
// ----------------------------------------------------------------------------
module h2b64_queue
   import h2b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  bundle_type bundle,
   output logic       room,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] b64_char
   output logic       rsp_tlast    // last_out
);

   entry_type entries_ff [QUEUE_DEPTH];

   logic [QPTR_W-1:0] head_ff,  head_in;
   logic [QPTR_W-1:0] tail_ff,  tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] after_pop;
   logic [QCNT_W-1:0] push_count;
   logic              pop;

   assign rsp_tvalid = count_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign after_pop  = count_ff - QCNT_W'(pop);
   assign room       = after_pop <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
   assign push_count = push_en ? QCNT_W'(bundle.count) : '0;

   always_comb begin
      count_in = after_pop + push_count;
      head_in  = head_ff + QPTR_W'(pop);
      tail_in  = tail_ff + QPTR_W'(push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (push_en && 3'(i) < bundle.count) begin
            entries_ff[tail_ff + QPTR_W'(i)] <= '{b64_char: bundle.chars[i],
                                                 last_out: bundle.lasts[i]};
         end
      end
   end

   assign rsp_tdata = entries_ff[head_ff].b64_char;
   assign rsp_tlast = entries_ff[head_ff].last_out;

endmodule

/* rtl/hex_to_base64_encoder.sv */
// ----------------------------------------------------------------------------
// hex_to_base64_encoder
// streams ascii hex digits in, streams base64 characters out
//
// req channel: one ascii character per transaction in req_tdata, req_tlast
// marks the end of a message; characters that are not hex digits are skipped
// rsp channel: one base64 character or '=' per transaction, rsp_tlast on the
// final character of a message
// path: an accepted transaction waits in the input register and, once taken,
// writes its characters into the queue, from which rsp presents them
// throughput: one req transaction per cycle; rsp sends one character per cycle
// while rsp_tready is high, and an end-of-message transaction may give up to four
// characters, which an eight-entry character queue absorbs; req stalls only while
// that queue could not hold four more
// reset: clears the staged transaction, the bit accumulator, the character
// phase and the queue; rsp_tvalid is low after reset
// rsp stall: rsp_tdata and rsp_tlast hold, the queue fills, then req_tready
// drops; nothing is lost
// ----------------------------------------------------------------------------
module hex_to_base64_encoder
   import h2b64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input character stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] hex_char
   input  logic       req_tlast,   // end_of_message
   // base64 character stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] b64_char
   output logic       rsp_tlast    // last_out
);

   logic       item_valid;
   item_type   item;
   logic       take;
   logic       room;
   bundle_type bundle;

   // input register
   h2b64_stage u_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // packs nibbles into sextets, flushes and pads at end of message
   h2b64_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .room       (room),
      .take       (take),
      .bundle     (bundle)
   );

   // result register bank, drains one character per cycle while rsp_tready is high
   h2b64_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (take),
      .bundle     (bundle),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/h2b64_checker.sv */
// ----------------------------------------------------------------------------
// h2b64_checker
// port-level checks for the hex to base64 encoder
// ----------------------------------------------------------------------------
`include "hex_to_base64_encoder_macros.svh"

module h2b64_checker
   import h2b64_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic legal_char;
   logic pad_mid;

   assign legal_char = (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h5A)
                    || (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h7A)
                    || (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39)
                    || rsp_tdata == 8'h2B || rsp_tdata == 8'h2F
                    || rsp_tdata == PAD_CHAR;
   assign pad_mid    = rsp_tvalid && rsp_tready && rsp_tdata == PAD_CHAR && !rsp_tlast;

   // a stalled character holds
   `H2B64_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // only alphabet characters and padding leave the block
   `H2B64_ASSERT_NOW(a_rsp_legal, clock, reset, rsp_tvalid, legal_char)

   // padding runs without a gap up to the closing character
   `H2B64_ASSERT_NEXT(a_pad_run, clock, reset, pad_mid, rsp_tvalid && rsp_tdata == PAD_CHAR)

   // right after reset nothing comes out and req is open
   `H2B64_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid && req_tready)

endmodule

bind hex_to_base64_encoder h2b64_checker u_h2b64_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
